### rtl/set_membership_table_top_assert.svh
// ----------------------------------------------------------------------------
// set_membership_table_top_assert.svh
// Assertion macros for the set membership table. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SET_MEMBERSHIP_TABLE_TOP_ASSERT_SVH
`define SET_MEMBERSHIP_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked on clk_i, disabled while rst_ni is low
`define SMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("smt assertion failed");

// Clocked on clk_i, also checked during reset
`define SMT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("smt assertion failed during or after reset");

`else

`define SMT_ASSERT(lbl, prop)
`define SMT_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### rtl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Sizes, request kinds and status codes of the set membership table.
// ----------------------------------------------------------------------------
package smt_pkg;

  // Store size and derived index / count widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Payload field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  // Request kinds; code 3 is unused and treated as a query
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_QUERY    = 3'd5
  } status_e;

endpackage

### rtl/smt_req_if.sv
// ----------------------------------------------------------------------------
// smt_req_if
// Request channel: valid/ready handshake with kind and value.
// ----------------------------------------------------------------------------
interface smt_req_if;
  logic                                valid;
  logic                                ready;
  logic [smt_pkg::KIND_W-1:0]          kind;
  logic signed [smt_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

### rtl/smt_rsp_if.sv
// ----------------------------------------------------------------------------
// smt_rsp_if
// Response channel: valid/ready handshake with status, found, position, count.
// ----------------------------------------------------------------------------
interface smt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [smt_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [smt_pkg::POS_W-1:0]    position;
  logic [smt_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output found, output position,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input count, output ready);
endinterface

### rtl/set_membership_table_top.sv
// Sequence: after accept, the search reads the held entries in order (skipped
// when empty); a remove then shifts the later entries down before the response.
// Throughput: one request at a time; the next is taken only after the response
// is committed, which waits out any response stall; search and shift together
// touch each held entry once, one per cycle through the read port.
// Reset: the count clears to zero; store contents stay undefined (no sweep).
// ----------------------------------------------------------------------------
// set_membership_table_top
// Packed insertion-ordered set with add, remove and membership query.
// ----------------------------------------------------------------------------
`include "set_membership_table_top_assert.svh"

module set_membership_table_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  smt_req_if.sink         req_i,
  smt_rsp_if.source       rsp_o
);
  import smt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_e;

  // Entry store, one read and one write port, registered read
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;

  // Control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic               hit_q, hit_d;
  kind_e              kind_q, kind_d;
  logic [VALUE_W-1:0] value_q, value_d;

  // Output register
  logic                rsp_valid_q, rsp_valid_d;
  status_e             status_q, status_d;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    rpos_q, rpos_d;
  logic [CNT_W-1:0]    rcount_q, rcount_d;

  logic               req_xfer;
  logic               slot_free;
  logic [CNT_W-1:0]   idx_nxt1;
  logic [CNT_W-1:0]   idx_nxt2;
  logic               last_entry;
  logic               store_full;
  status_e            status_sel;

  assign req_i.ready    = (state_q == S_IDLE);
  assign req_xfer       = req_i.valid && req_i.ready;
  assign slot_free      = !rsp_valid_q || rsp_o.ready;
  assign idx_nxt1       = CNT_W'(idx_q) + CNT_W'(1);
  assign idx_nxt2       = CNT_W'(idx_q) + CNT_W'(2);
  assign last_entry     = (idx_nxt1 == count_q);
  assign store_full     = (count_q >= CNT_W'(CAPACITY));

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.found    = found_q;
  assign rsp_o.position = POS_W'(rpos_q);
  assign rsp_o.count    = COUNT_W'(rcount_q);

  // Status decode from request kind and search outcome
  always_comb begin
    case (kind_q)
      KIND_ADD: begin
        if (hit_q)           status_sel = ST_PRESENT;
        else if (store_full) status_sel = ST_FULL;
        else                 status_sel = ST_ADDED;
      end
      KIND_REMOVE: status_sel = hit_q ? ST_REMOVED : ST_NOTFOUND;
      default:     status_sel = ST_QUERY;
    endcase
  end

  // Sequencer: search, shift-down, commit and respond
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    hit_d       = hit_q;
    kind_d      = kind_q;
    value_d     = value_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    status_d    = status_q;
    found_d     = found_q;
    rpos_d      = rpos_q;
    rcount_d    = rcount_q;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = rd_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          kind_d  = kind_e'(req_i.kind);
          value_d = req_i.value;
          idx_d   = '0;
          hit_d   = 1'b0;
          pos_d   = '0;
          state_d = (count_q == '0) ? S_RESP : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (rd_data_q == value_q) begin
          hit_d = 1'b1;
          pos_d = idx_q;
          if (kind_q == KIND_REMOVE && !last_entry) begin
            rd_addr = idx_nxt1[IDX_W-1:0];
            state_d = S_SHIFT;
          end else begin
            state_d = S_RESP;
          end
        end else if (last_entry) begin
          state_d = S_RESP;
        end else begin
          rd_addr = idx_nxt1[IDX_W-1:0];
          idx_d   = idx_nxt1[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        // entry idx+1 was read last cycle; move it down to idx
        mem_we = 1'b1;
        if (idx_nxt2 < count_q) begin
          rd_addr = idx_nxt2[IDX_W-1:0];
          idx_d   = idx_nxt1[IDX_W-1:0];
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          if (kind_q == KIND_ADD && !hit_q && !store_full) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IDX_W-1:0];
            mem_wdata = value_q;
            count_d   = count_q + CNT_W'(1);
          end else if (kind_q == KIND_REMOVE && hit_q) begin
            count_d   = count_q - CNT_W'(1);
          end
          rsp_valid_d = 1'b1;
          status_d    = status_sel;
          found_d     = hit_q;
          rpos_d      = pos_q;
          rcount_d    = count_d;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    hit_q    <= hit_d;
    kind_q   <= kind_d;
    value_q  <= value_d;
    status_q <= status_d;
    found_q  <= found_d;
    rpos_q   <= rpos_d;
    rcount_q <= rcount_d;
  end

  // Entry store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  `SMT_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))
  `SMT_ASSERT(a_search_in_range, state_q == S_SEARCH |-> CNT_W'(idx_q) < count_q)
  `SMT_ASSERT(a_accept_leaves_idle, req_xfer |=> state_q != S_IDLE)
  `SMT_ASSERT(a_removed_found,
    rsp_valid_q && status_q == ST_REMOVED |-> found_q && rcount_q < CNT_W'(CAPACITY))
  `SMT_ASSERT(a_resp_on_commit,
    state_q == S_RESP && slot_free |=> rsp_valid_q && state_q == S_IDLE)

endmodule
